// ----- design/rao_pkg.sv -----
package rao_pkg;

  localparam int SIDE      = 3;
  localparam int SITES     = SIDE * SIDE * SIDE;
  localparam int STATE_W   = 2 * SITES;
  localparam int POS_W     = $clog2(STATE_W);
  localparam int SITE_W    = 5;
  localparam int COUNT_W   = 24;
  localparam int POWER_W   = COUNT_W + 1;
  localparam int SUM_W     = COUNT_W + 1;
  localparam int AVG_W     = 16;
  localparam int FRAC_W    = 14;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int DIV_W     = COUNT_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [COUNT_W-1:0] MAX_STEPS_RESET = COUNT_W'(10000000);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic search_step;
    logic walk_init;
    logic walk_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } rao_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic search_end;
    logic abandon;
    logic walk_done;
    logic div_done;
  } rao_status_t;

  // Current value of a site; an index past the lattice reads as zero
  function automatic logic now_bit(input logic [STATE_W-1:0] s,
                                   input logic [SITE_W-1:0]  idx);
    logic [POS_W-1:0] pos;
    logic             b;
    pos = POS_W'({idx, 1'b0});
    if (idx < SITE_W'(SITES)) begin
      b = s[pos];
    end else begin
      b = 1'b0;
    end
    return b;
  endfunction

  function automatic int site_index(input int x, input int y, input int z);
    return x + SIDE * y + SIDE * SIDE * z;
  endfunction

  // One step of the lattice: new current = six neighbours ^ previous
  function automatic logic [STATE_W-1:0] lattice_advance(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] r;
    int                 x;
    int                 y;
    int                 z;
    int                 i;
    int                 xp;
    int                 xm;
    int                 yp;
    int                 ym;
    int                 zp;
    int                 zm;
    logic               nv;
    r = '0;
    for (z = 0; z < SIDE; z++) begin
      for (y = 0; y < SIDE; y++) begin
        for (x = 0; x < SIDE; x++) begin
          i  = site_index(x, y, z);
          xp = (x == SIDE - 1) ? 0 : x + 1;
          xm = (x == 0) ? SIDE - 1 : x - 1;
          yp = (y == SIDE - 1) ? 0 : y + 1;
          ym = (y == 0) ? SIDE - 1 : y - 1;
          zp = (z == SIDE - 1) ? 0 : z + 1;
          zm = (z == 0) ? SIDE - 1 : z - 1;
          nv = s[2 * site_index(xp, y, z)] ^ s[2 * site_index(xm, y, z)]
             ^ s[2 * site_index(x, yp, z)] ^ s[2 * site_index(x, ym, z)]
             ^ s[2 * site_index(x, y, zp)] ^ s[2 * site_index(x, y, zm)]
             ^ s[2 * i + 1];
          r[2 * i]     = nv;
          r[2 * i + 1] = s[2 * i];
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- design/rao_ctrl.sv -----
module rao_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rao_pkg::rao_cmd_t    cmd,
  input  rao_pkg::rao_status_t st
);
  import rao_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SEARCH,
    WALK,
    DIV,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SEARCH;
        end
      end
      SEARCH: begin
        if (st.search_end) begin
          if (st.abandon) begin
            state_next = FINISH;
          end else begin
            cmd.walk_init = 1'b1;
            state_next    = WALK;
          end
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      WALK: begin
        if (st.walk_done) begin
          cmd.div_init = 1'b1;
          state_next   = DIV;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      DIV: begin
        if (st.div_done) begin
          state_next = FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      FINISH: begin
        // hold until the output register is free or being drained
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (out_valid && out_stall) || cmd.load_out;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == SEARCH)
    else $error("accepted item did not start the search");

endmodule

// ----- design/rao_datapath.sv -----
module rao_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rao_pkg::COUNT_W-1:0]       cfg_data,
  input  logic [rao_pkg::STATE_W-1:0]       initial_state,
  input  logic [rao_pkg::SITE_W-1:0]        site_a,
  input  logic [rao_pkg::SITE_W-1:0]        site_b,
  input  rao_pkg::rao_cmd_t                 cmd,
  output rao_pkg::rao_status_t              st,
  output logic [rao_pkg::COUNT_W-1:0]       orbit_length,
  output logic signed [rao_pkg::SUM_W-1:0]  correlation_sum,
  output logic signed [rao_pkg::AVG_W-1:0]  average_q,
  output logic                              too_long
);
  import rao_pkg::*;

  logic [COUNT_W-1:0]       max_steps;
  logic [STATE_W-1:0]       start_state;
  logic [SITE_W-1:0]        sa;
  logic [SITE_W-1:0]        sb;
  logic [STATE_W-1:0]       tortoise;
  logic [STATE_W-1:0]       hare;
  logic [STATE_W-1:0]       walker;
  logic [POWER_W-1:0]       power;
  logic [COUNT_W-1:0]       lambda;
  logic [COUNT_W-1:0]       walk_count;
  logic signed [SUM_W-1:0]  sum;
  logic [DIV_W-1:0]         div_q;
  logic [COUNT_W-1:0]       rem;
  logic [DIV_CNT_W-1:0]     div_count;

  logic [STATE_W-1:0]       hare_adv;
  logic [STATE_W-1:0]       walker_adv;
  logic                     spins_match;
  logic signed [SUM_W-1:0]  neg_sum;
  logic [COUNT_W-1:0]       sum_mag;
  logic [COUNT_W:0]         trial;
  logic [COUNT_W+1:0]       diff;
  logic [AVG_W-1:0]         quo_ext;
  logic [AVG_W-1:0]         avg_val;

  assign hare_adv    = lattice_advance(hare);
  assign walker_adv  = lattice_advance(walker);
  assign spins_match = (now_bit(walker, sa) == now_bit(walker, sb));
  assign neg_sum     = -sum;
  assign sum_mag     = sum[SUM_W-1] ? neg_sum[COUNT_W-1:0] : sum[COUNT_W-1:0];

  // restoring divide, one quotient bit per step
  assign trial   = {rem, div_q[DIV_W-1]};
  assign diff    = {1'b0, trial} - {2'b00, lambda};
  assign quo_ext = AVG_W'(div_q[QUO_W-1:0]);
  assign avg_val = sum[SUM_W-1] ? -quo_ext : quo_ext;

  assign st.abandon    = (lambda >= max_steps);
  assign st.search_end = (tortoise == hare) || st.abandon;
  assign st.walk_done  = (walk_count == lambda);
  assign st.div_done   = (div_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps <= MAX_STEPS_RESET;
      power     <= POWER_W'(1);
      lambda    <= COUNT_W'(1);
      div_count <= '0;
    end else begin
      if (cfg_write) begin
        max_steps <= cfg_data;
      end
      if (cmd.load) begin
        start_state <= initial_state;
        sa          <= site_a;
        sb          <= site_b;
        tortoise    <= initial_state;
        hare        <= lattice_advance(initial_state);
        power       <= POWER_W'(1);
        lambda      <= COUNT_W'(1);
      end
      if (cmd.search_step) begin
        // a new power of two: move the tortoise up and restart the count
        if ({1'b0, lambda} == power) begin
          tortoise <= hare;
          power    <= {power[POWER_W-2:0], 1'b0};
          lambda   <= COUNT_W'(1);
        end else begin
          lambda <= lambda + COUNT_W'(1);
        end
        hare <= hare_adv;
      end
      if (cmd.walk_init) begin
        walker     <= start_state;
        walk_count <= '0;
        sum        <= '0;
      end
      if (cmd.walk_step) begin
        sum        <= spins_match ? sum + SUM_W'(1) : sum - SUM_W'(1);
        walker     <= walker_adv;
        walk_count <= walk_count + COUNT_W'(1);
      end
      if (cmd.div_init) begin
        div_q     <= {sum_mag, {FRAC_W{1'b0}}};
        rem       <= '0;
        div_count <= DIV_CNT_W'(DIV_W);
      end
      if (cmd.div_step) begin
        if (!diff[COUNT_W+1]) begin
          rem   <= diff[COUNT_W-1:0];
          div_q <= {div_q[DIV_W-2:0], 1'b1};
        end else begin
          rem   <= trial[COUNT_W-1:0];
          div_q <= {div_q[DIV_W-2:0], 1'b0};
        end
        div_count <= div_count - DIV_CNT_W'(1);
      end
      if (cmd.load_out) begin
        if (st.abandon) begin
          orbit_length    <= '0;
          correlation_sum <= '0;
          average_q       <= '0;
          too_long        <= 1'b1;
        end else begin
          orbit_length    <= lambda;
          correlation_sum <= sum;
          average_q       <= avg_val;
          too_long        <= 1'b0;
        end
      end
    end
  end

  a_lambda_le_power: assert property (@(posedge clk) disable iff (rst)
    {1'b0, lambda} <= power)
    else $error("cycle count ran past the power of two");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    div_count != '0 |-> rem < lambda)
    else $error("divider remainder not below the divisor");

endmodule

// ----- design/reversible_automaton_orbit_average.sv -----
// L is the orbit length and S the number of Brent search steps (L - 1 to about 3L),
// one lattice step per cycle; an abandoned item skips the walk and the divide.
// Next item is taken the cycle after the result is loaded, so items never overlap;
// the search and walk use the lattice step logic, the divide a 38-step divider.
// Reset (synchronous): controller idle, no result pending, max_steps = 10000000.
module reversible_automaton_orbit_average (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rao_pkg::COUNT_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rao_pkg::STATE_W-1:0]       initial_state,
  input  logic [rao_pkg::SITE_W-1:0]        site_a,
  input  logic [rao_pkg::SITE_W-1:0]        site_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rao_pkg::COUNT_W-1:0]       orbit_length,
  output logic signed [rao_pkg::SUM_W-1:0]  correlation_sum,
  output logic signed [rao_pkg::AVG_W-1:0]  average_q,
  output logic                              too_long
);
  import rao_pkg::*;

  rao_cmd_t    cmd;
  rao_status_t st;

  rao_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  rao_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .initial_state   (initial_state),
    .site_a          (site_a),
    .site_b          (site_b),
    .cmd             (cmd),
    .st              (st),
    .orbit_length    (orbit_length),
    .correlation_sum (correlation_sum),
    .average_q       (average_q),
    .too_long        (too_long)
  );

endmodule

// ----- dv/reversible_automaton_orbit_average_tb.sv -----
module reversible_automaton_orbit_average_tb;
  import rao_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_ITEMS    = 65;
  localparam int MAX_GAP        = 13;

  typedef logic [STATE_W-1:0] lattice_t;
  typedef logic [SITE_W-1:0]  site_t;

  typedef struct packed {
    logic [COUNT_W-1:0] orbit_length;
    logic [SUM_W-1:0]   correlation_sum;
    logic [AVG_W-1:0]   average_q;
    logic               too_long;
  } orbit_result_t;

  // every site current 1 / previous 0, and the reverse: each turns into the other, period two
  localparam lattice_t UNIFORM_NOW  = {SITES{2'b01}};
  localparam lattice_t UNIFORM_PREV = {SITES{2'b10}};

  logic                      clk             = 1'b0;
  logic                      rst             = 1'b1;
  logic                      cfg_write       = 1'b0;
  logic [COUNT_W-1:0]        cfg_data        = '0;
  logic                      in_valid        = 1'b0;
  logic                      in_stall;
  lattice_t                  initial_state   = '0;
  site_t                     site_a          = '0;
  site_t                     site_b          = '0;
  logic                      out_valid;
  logic                      out_stall       = 1'b0;
  logic [COUNT_W-1:0]        orbit_length;
  logic signed [SUM_W-1:0]   correlation_sum;
  logic signed [AVG_W-1:0]   average_q;
  logic                      too_long;

  logic [COUNT_W-1:0] search_limit = MAX_STEPS_RESET;
  orbit_result_t      pending_orbits[$];
  bit                 sender_quiet   = 1'b0;
  bit                 receiver_quiet = 1'b0;
  int                 error_count     = 0;
  int                 items_sent      = 0;
  int                 results_checked = 0;
  int                 abandoned_count = 0;
  int                 limit_writes    = 0;

  reversible_automaton_orbit_average dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .initial_state   (initial_state),
    .site_a          (site_a),
    .site_b          (site_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .orbit_length    (orbit_length),
    .correlation_sum (correlation_sum),
    .average_q       (average_q),
    .too_long        (too_long)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int wrap_site(input int x, input int y, input int z);
    return (x % SIDE) + SIDE * (y % SIDE) + SIDE * SIDE * (z % SIDE);
  endfunction

  function automatic lattice_t advance_lattice(input lattice_t s);
    lattice_t r;
    int       i;
    int       x;
    int       y;
    int       z;
    logic     p;
    r = '0;
    for (i = 0; i < SITES; i++) begin
      x = i % SIDE;
      y = (i / SIDE) % SIDE;
      z = i / (SIDE * SIDE);
      p = s[2 * i + 1];
      p ^= s[2 * wrap_site(x + 1, y, z)] ^ s[2 * wrap_site(x + SIDE - 1, y, z)];
      p ^= s[2 * wrap_site(x, y + 1, z)] ^ s[2 * wrap_site(x, y + SIDE - 1, z)];
      p ^= s[2 * wrap_site(x, y, z + 1)] ^ s[2 * wrap_site(x, y, z + SIDE - 1)];
      r[2 * i]     = p;
      r[2 * i + 1] = s[2 * i];
    end
    return r;
  endfunction

  // a site past the lattice always reads as zero
  function automatic logic site_value(input lattice_t s, input site_t idx);
    if (int'(idx) >= SITES) begin
      return 1'b0;
    end
    return s[2 * int'(idx)];
  endfunction

  function automatic orbit_result_t predict_orbit(input lattice_t start, input site_t a,
                                                  input site_t b,
                                                  input logic [COUNT_W-1:0] limit);
    orbit_result_t res;
    lattice_t      slow;
    lattice_t      fast;
    lattice_t      walk;
    longint        power;
    longint        span;
    longint        lim;
    longint        total;
    longint        avg;
    longint        k;
    res   = '0;
    lim   = limit;
    slow  = start;
    fast  = advance_lattice(start);
    power = 1;
    span  = 1;
    while (slow != fast && span < lim) begin
      if (power == span) begin
        slow  = fast;
        power = power * 2;
        span  = 0;
      end
      fast = advance_lattice(fast);
      span++;
    end
    // give up at the limit even when the cycle closed right on it
    if (span >= lim) begin
      res.too_long = 1'b1;
      return res;
    end
    walk  = start;
    total = 0;
    for (k = 0; k < span; k++) begin
      total += (site_value(walk, a) == site_value(walk, b)) ? 1 : -1;
      walk = advance_lattice(walk);
    end
    avg = (total * 16384) / span;
    res.orbit_length    = span[COUNT_W-1:0];
    res.correlation_sum = total[SUM_W-1:0];
    res.average_q       = avg[AVG_W-1:0];
    return res;
  endfunction

  task automatic send_lattice(input lattice_t s, input site_t a, input site_t b);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    initial_state <= s;
    site_a        <= a;
    site_b        <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_orbits.push_back(predict_orbit(s, a, b, search_limit));
    items_sent++;
  endtask

  // hold off until every outstanding item has produced its result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_orbits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_steps(input logic [COUNT_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write    <= 1'b0;
    search_limit = value;
    limit_writes++;
  endtask

  function automatic lattice_t pick_lattice();
    lattice_t r;
    int       i;
    r = lattice_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = '1;
      2: r = UNIFORM_NOW;
      3: r = UNIFORM_PREV;
      4: for (i = 0; i < SITES; i++) r[2 * i + 1] = r[2 * i];
      5: r = lattice_t'(1) << $urandom_range(0, STATE_W - 1);
      default: ;
    endcase
    return r;
  endfunction

  function automatic site_t pick_site();
    if ($urandom_range(0, 7) == 0) begin
      return site_t'($urandom_range(SITES, 2 ** SITE_W - 1));
    end
    return site_t'($urandom_range(0, SITES - 1));
  endfunction

  task automatic test_special_states();
    send_lattice('0, 0, SITES - 1);
    send_lattice('1, 0, 0);
    send_lattice('1, SITES - 1, 2 ** SITE_W - 1);
    send_lattice(UNIFORM_NOW, 13, 13);
    send_lattice(UNIFORM_PREV, 2 ** SITE_W - 1, SITES);
    send_lattice(lattice_t'({$urandom, $urandom}), SITES, 5);
    send_lattice(lattice_t'({$urandom, $urandom}), 5, 5);
    send_lattice(lattice_t'({$urandom, $urandom}), 1, 2);
  endtask

  task automatic test_search_limit();
    set_max_steps('0);
    send_lattice('0, 0, 1);
    send_lattice(lattice_t'({$urandom, $urandom}), 3, 4);
    // a fixed point closes at one step, still abandoned at limit one
    set_max_steps(1);
    send_lattice('0, 0, 1);
    send_lattice(lattice_t'({$urandom, $urandom}), 7, 8);
    set_max_steps(2);
    send_lattice(UNIFORM_NOW, 0, 26);
    set_max_steps(3);
    send_lattice(UNIFORM_NOW, 0, 26);
    send_lattice('0, 9, 10);
    set_max_steps(6);
    send_lattice(lattice_t'({$urandom, $urandom}), 11, 12);
    set_max_steps(7);
    send_lattice(lattice_t'({$urandom, $urandom}), 14, 15);
    send_lattice(lattice_t'({$urandom, $urandom}), 16, 17);
    set_max_steps('1);
    send_lattice(lattice_t'({$urandom, $urandom}), 18, 19);
    send_lattice(lattice_t'({$urandom, $urandom}), 20, 21);
  endtask

  task automatic test_random_orbits();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0:       set_max_steps('0);
        1, 2:    set_max_steps(MAX_STEPS_RESET);
        3:       set_max_steps('1);
        4:       set_max_steps(COUNT_W'($urandom));
        default: set_max_steps(COUNT_W'($urandom_range(1, 8)));
      endcase
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) begin
          wait_idle();
        end
        send_lattice(pick_lattice(), pick_site(), pick_site());
      end
    end
  endtask

  initial begin : result_monitor
    int            hold;
    orbit_result_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_orbits.size() == 0) begin
          $error("result with no item outstanding: orbit_length %0d", orbit_length);
          error_count++;
        end else begin
          want = pending_orbits.pop_front();
          results_checked++;
          if (want.too_long) begin
            abandoned_count++;
          end
          if (orbit_length !== want.orbit_length) begin
            $error("orbit_length: expected %0d, got %0d", want.orbit_length, orbit_length);
            error_count++;
          end
          if (correlation_sum !== want.correlation_sum) begin
            $error("correlation_sum: expected %0d, got %0d",
                   $signed(want.correlation_sum), correlation_sum);
            error_count++;
          end
          if (average_q !== want.average_q) begin
            $error("average_q: expected %0d, got %0d", $signed(want.average_q), average_q);
            error_count++;
          end
          if (too_long !== want.too_long) begin
            $error("too_long: expected %0d, got %0d", want.too_long, too_long);
            error_count++;
          end
        end
        hold = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end else if (out_valid === 1'b1 && hold != 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("reversible_automaton_orbit_average test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_special_states();
    test_search_limit();
    test_random_orbits();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d lattice items sent, %0d orbit results checked, %0d max_steps writes",
             items_sent, results_checked, limit_writes);
    $display("%0d searches gave up at the step limit", abandoned_count);
    if (error_count == 0 && pending_orbits.size() == 0) begin
      $display("reversible_automaton_orbit_average test passed");
    end else begin
      $display("reversible_automaton_orbit_average test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/rao_pkg.sv
design/rao_ctrl.sv
design/rao_datapath.sv
design/reversible_automaton_orbit_average.sv
dv/reversible_automaton_orbit_average_tb.sv
